// File: design/octc_pkg.sv
// shared types and constants of the oven cook timer controller
`default_nettype none

package octc_pkg;

  // width of all tick counters
  localparam int unsigned TimeBits = 20;

  localparam logic [TimeBits-1:0] MaxCookReset = TimeBits'(599900);
  localparam logic [TimeBits-1:0] TenSecTicks  = TimeBits'(1000);
  localparam logic [TimeBits-1:0] OneMinTicks  = TimeBits'(6000);
  localparam logic [TimeBits-1:0] TenMinTicks  = TimeBits'(60000);

  // ticks / 6000 as (ticks * MinRecip) >> MinShift, exact for all 20-bit ticks
  localparam int unsigned MinShift = 32;
  localparam logic [19:0] MinRecip = 20'd715828;

  // remainder / 100 as (rem * SecRecip) >> SecShift, exact below 6000
  localparam int unsigned RemBits  = 13;
  localparam int unsigned SecShift = 19;
  localparam logic [12:0] SecRecip = 13'd5243;

  // mode codes as seen on the result item
  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeHeat  = 2'd1;
  localparam logic [1:0] ModePause = 2'd2;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StHeat  = 3'b010,
    StPause = 3'b100
  } oven_state_e;

  // one input item
  typedef struct packed {
    logic add_ten_min;
    logic add_one_min;
    logic add_ten_sec;
    logic stop_press;
    logic start_press;
    logic tick;
  } btn_t;

  // control stage result passed to the display pipeline
  typedef struct packed {
    logic [1:0]          mode;
    logic [TimeBits-1:0] shown;
  } disp_req_t;

endpackage

`default_nettype wire

// File: design/octc_ctrl.sv
// mode state machine, cook time registers and first pipeline register
`default_nettype none

module octc_ctrl
  import octc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [19:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output      logic           in_ready_o,
  input  wire btn_t           in_btn_i,
  output      logic           req_valid_o,
  input  wire logic           req_ready_i,
  output      disp_req_t      req_o
);

  oven_state_e         state_q, state_d;
  logic [TimeBits-1:0] cook_q, cook_d;
  logic [TimeBits-1:0] rem_q, rem_d;
  logic [TimeBits-1:0] max_q;
  logic [TimeBits-1:0] rem_dec;
  logic [TimeBits-1:0] add_step;
  logic [TimeBits:0]   add_sum;
  logic [TimeBits-1:0] add_sat;
  logic                req_valid_q;
  disp_req_t           req_q, req_d;
  logic                accept;

  assign in_ready_o  = !req_valid_q || req_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  // button step in idle priority order
  always_comb begin
    priority if (in_btn_i.add_ten_sec) begin
      add_step = TenSecTicks;
    end else if (in_btn_i.add_one_min) begin
      add_step = OneMinTicks;
    end else begin
      add_step = TenMinTicks;
    end
  end

  assign add_sum = {1'b0, cook_q} + {1'b0, add_step};
  assign add_sat = (add_sum > {1'b0, max_q}) ? max_q : add_sum[TimeBits-1:0];
  assign rem_dec = (in_btn_i.tick && rem_q != '0) ? rem_q - 1'b1 : rem_q;

  always_comb begin
    state_d = state_q;
    cook_d  = cook_q;
    rem_d   = rem_q;
    unique case (state_q)
      StHeat: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          cook_d  = '0;
          state_d = StIdle;
        end else if (in_btn_i.stop_press) begin
          state_d = StPause;
        end
      end
      StPause: begin
        if (in_btn_i.start_press) begin
          state_d = StHeat;
        end else if (in_btn_i.stop_press) begin
          cook_d  = '0;
          rem_d   = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_btn_i.start_press && cook_q != '0) begin
          rem_d   = cook_q;
          state_d = StHeat;
        end else if (in_btn_i.add_ten_sec || in_btn_i.add_one_min ||
                     in_btn_i.add_ten_min) begin
          cook_d = add_sat;
        end else if (in_btn_i.stop_press) begin
          cook_d = '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    unique case (state_d)
      StHeat:  req_d.mode = ModeHeat;
      StPause: req_d.mode = ModePause;
      default: req_d.mode = ModeIdle;
    endcase
    req_d.shown = (state_d == StHeat || state_d == StPause) ? rem_d : cook_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cook_q      <= '0;
      rem_q       <= '0;
      max_q       <= MaxCookReset;
      req_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i[TimeBits-1:0];
      end
      if (accept) begin
        state_q <= state_d;
        cook_q  <= cook_d;
        rem_q   <= rem_d;
      end
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

`ifndef SYNTHESIS
  a_heat_has_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StHeat || state_q == StPause) |-> rem_q != '0)
    else $error("heating or paused with no remaining time");
  a_req_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> req_q.shown == ((state_q == StIdle) ? cook_q : rem_q))
    else $error("shown time does not follow the mode state");
`endif

endmodule

`default_nettype wire

// File: design/octc_disp.sv
// two-stage minutes:seconds conversion with the result register
`default_nettype none

module octc_disp
  import octc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output      logic        req_ready_o,
  input  wire disp_req_t   req_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [1:0]  mode_o,
  output      logic [7:0]  minutes_o,
  output      logic [5:0]  seconds_o
);

  logic                  b_valid_q, c_valid_q;
  logic                  b_en, c_en;
  logic [TimeBits+19:0]  min_prod;
  logic [7:0]            min_b_q;
  logic [TimeBits-1:0]   shown_b_q;
  logic [1:0]            mode_b_q;
  logic [TimeBits-1:0]   min_x6000;
  logic [TimeBits-1:0]   rem_full;
  logic [RemBits-1:0]    rem_b;
  logic [2*RemBits-1:0]  sec_prod;
  logic [1:0]            mode_c_q;
  logic [7:0]            min_c_q;
  logic [5:0]            sec_c_q;

  assign c_en        = !c_valid_q || out_ready_i;
  assign b_en        = !b_valid_q || c_en;
  assign req_ready_o = b_en;

  // stage b: minutes by reciprocal multiply
  assign min_prod = (TimeBits+20)'(req_i.shown) * (TimeBits+20)'(MinRecip);

  // stage c: remainder by shift-add of 6000 = 4096+1024+512+256+128-16
  always_comb begin
    min_x6000 = (TimeBits'(min_b_q) << 12) + (TimeBits'(min_b_q) << 10)
              + (TimeBits'(min_b_q) << 9) + (TimeBits'(min_b_q) << 8)
              + (TimeBits'(min_b_q) << 7) - (TimeBits'(min_b_q) << 4);
  end
  assign rem_full = shown_b_q - min_x6000;
  assign rem_b    = rem_full[RemBits-1:0];
  assign sec_prod = (2*RemBits)'(rem_b) * (2*RemBits)'(SecRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (b_en) begin
        b_valid_q <= req_valid_i;
      end
      if (c_en) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en && req_valid_i) begin
      min_b_q   <= min_prod[MinShift+7:MinShift];
      shown_b_q <= req_i.shown;
      mode_b_q  <= req_i.mode;
    end
    if (c_en && b_valid_q) begin
      min_c_q  <= min_b_q;
      sec_c_q  <= sec_prod[SecShift+5:SecShift];
      mode_c_q <= mode_b_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign mode_o      = mode_c_q;
  assign minutes_o   = min_c_q;
  assign seconds_o   = sec_c_q;

`ifndef SYNTHESIS
  a_min_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (min_x6000 <= shown_b_q && rem_full < TimeBits'(6000)))
    else $error("minutes quotient off by one");
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> sec_c_q < 6'd60)
    else $error("seconds out of range");
`endif

endmodule

`default_nettype wire

// File: design/oven_cook_timer_controller_unit.sv
// top level of the oven cook timer controller
`default_nettype none

// Cook timer for a microwave oven with three modes: idle, heating and paused.
// Each input item is one step: an optional 10 ms tick and single-shot button
// events. In idle, start (with a nonzero cook time) begins heating; otherwise
// add ten seconds, add one minute, add ten minutes and stop act in that
// priority, additions saturating at max_cook_ticks. While heating the
// remaining time drops by one per tick; at zero the block returns to idle and
// clears the time, otherwise stop pauses. While paused the count is frozen:
// start resumes, stop clears and idles. Every item gives exactly one result
// item with the mode, the drive and lamp outputs and the shown time as
// minutes:seconds. One item is taken every cycle unless back-pressure from the
// output has filled the pipeline; a result is offered once it has passed
// three register stages (state update, minutes multiply, then remainder and
// seconds multiply into the output register). Write max_cook_ticks through
// cfg_we_i only while no items are in flight.

module oven_cook_timer_controller_unit
  import octc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // limit for the accumulated cook time, in ticks
  input  wire logic        cfg_we_i,
  input  wire logic [19:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // tick, start_press, stop_press, add_ten_sec, add_one_min, add_ten_min, pad
  input  wire logic [7:0]  s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // mode[1:0], motor_on, heater_on, red_lamp, yellow_lamp, green_lamp,
  // shown_minutes[7:0], shown_seconds[5:0], pad
  output      logic [23:0] m_axis_tdata_o
);

  btn_t       btn;
  logic       req_valid;
  logic       req_ready;
  disp_req_t  req;
  logic [1:0] mode;
  logic [7:0] minutes;
  logic [5:0] seconds;
  logic       heating;

  // unpack the input item, tick in the lowest bit
  assign btn = btn_t'(s_axis_tdata_i[5:0]);

  octc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_btn_i    (btn),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  octc_disp u_disp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .mode_o      (mode),
    .minutes_o   (minutes),
    .seconds_o   (seconds)
  );

  // motor, heater and red lamp all follow heating
  assign heating = (mode == ModeHeat);

  assign m_axis_tdata_o = {3'b000, seconds, minutes,
                           (mode == ModeIdle), (mode == ModePause),
                           heating, heating, heating, mode};

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the oven cook timer controller
`timescale 1ns / 100ps

module testbench;
  import octc_pkg::*;

  // button masks, bit order as in the input item
  localparam logic [5:0] BtnNone   = 6'b000000;
  localparam logic [5:0] BtnTick   = 6'b000001;
  localparam logic [5:0] BtnStart  = 6'b000010;
  localparam logic [5:0] BtnStop   = 6'b000100;
  localparam logic [5:0] BtnTenSec = 6'b001000;
  localparam logic [5:0] BtnOneMin = 6'b010000;
  localparam logic [5:0] BtnTenMin = 6'b100000;

  localparam logic [TimeBits-1:0] TicksPerSec = TimeBits'(100);
  localparam logic [19:0] LimitMax = 20'hFFFFF;
  localparam int SqueezeCycles = 300;

  // result item, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic [5:0] seconds;
    logic [7:0] minutes;
    logic       green;
    logic       yellow;
    logic       red;
    logic       heater;
    logic       motor;
    logic [1:0] mode;
  } oven_status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tick, start_press, stop_press, add_ten_sec, add_one_min, add_ten_min, pad
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // mode[1:0], motor_on, heater_on, red_lamp, yellow_lamp, green_lamp,
  // shown_minutes[7:0], shown_seconds[5:0], pad
  logic [23:0] m_axis_tdata_o;

  oven_cook_timer_controller_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer state as the block should hold it
  logic [1:0]          pred_mode   = ModeIdle;
  logic [TimeBits-1:0] pred_cook   = '0;
  logic [TimeBits-1:0] pred_remain = '0;
  logic [TimeBits-1:0] pred_limit  = MaxCookReset;

  btn_t         button_queue[$];
  oven_status_t status_due[$];
  int           bad_results = 0;
  int           n_results = 0;
  logic         squeeze_req = 1'b0;

  // addition that saturates at the cook limit
  function automatic logic [TimeBits-1:0] capped_add(logic [TimeBits-1:0] amount);
    logic [TimeBits:0] sum;
    sum = {1'b0, pred_cook} + {1'b0, amount};
    return (sum > {1'b0, pred_limit}) ? pred_limit : sum[TimeBits-1:0];
  endfunction

  // advance the timer by one item and return the status it shows afterwards
  function automatic oven_status_t cook_step(btn_t b);
    logic [TimeBits-1:0] shown;
    logic [TimeBits-1:0] mins;
    logic [TimeBits-1:0] secs;
    oven_status_t s;
    case (pred_mode)
      ModeHeat: begin
        // tick first, then zero ends the cook and wins over stop
        if (b.tick && pred_remain != '0) pred_remain = pred_remain - 1'b1;
        if (pred_remain == '0) begin
          pred_cook = '0;
          pred_mode = ModeIdle;
        end else if (b.stop_press) begin
          pred_mode = ModePause;
        end
      end
      ModePause: begin
        if (b.start_press) begin
          pred_mode = ModeHeat;
        end else if (b.stop_press) begin
          pred_cook   = '0;
          pred_remain = '0;
          pred_mode   = ModeIdle;
        end
      end
      default: begin
        pred_mode = ModeIdle;
        if (b.start_press && pred_cook != '0) begin
          pred_remain = pred_cook;
          pred_mode   = ModeHeat;
        end else if (b.add_ten_sec) begin
          pred_cook = capped_add(TenSecTicks);
        end else if (b.add_one_min) begin
          pred_cook = capped_add(OneMinTicks);
        end else if (b.add_ten_min) begin
          pred_cook = capped_add(TenMinTicks);
        end else if (b.stop_press) begin
          pred_cook = '0;
        end
      end
    endcase
    shown     = (pred_mode == ModeIdle) ? pred_cook : pred_remain;
    mins      = shown / OneMinTicks;
    secs      = (shown % OneMinTicks) / TicksPerSec;
    s         = '0;
    s.mode    = pred_mode;
    s.motor   = (pred_mode == ModeHeat);
    s.heater  = (pred_mode == ModeHeat);
    s.red     = (pred_mode == ModeHeat);
    s.yellow  = (pred_mode == ModePause);
    s.green   = (pred_mode == ModeIdle);
    s.minutes = mins[7:0];
    s.seconds = secs[5:0];
    return s;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic void put(logic [5:0] bits);
    button_queue.push_back(btn_t'(bits));
  endfunction

  // one cooking session: set the time, start, run with pauses, then clear
  function automatic int queue_session(int run_max, int add_lo, int add_hi, bit heavy);
    int pushed;
    int r;
    logic [5:0] b;
    pushed = 0;
    // a little noise between sessions
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3)) begin
        put(6'($urandom_range(0, 63)));
        pushed += 1;
      end
    end
    repeat ($urandom_range(add_lo, add_hi)) begin
      if (heavy && $urandom_range(0, 3) != 0) begin
        b = BtnTenMin;
      end else begin
        case ($urandom_range(0, 2))
          0:       b = BtnTenSec;
          1:       b = BtnOneMin;
          default: b = BtnTenMin;
        endcase
      end
      // extra buttons other than start, and stray ticks
      if ($urandom_range(0, 3) == 0) b |= 6'($urandom_range(0, 63)) & ~BtnStart;
      put(b);
      pushed += 1;
    end
    put(BtnStart | ($urandom_range(0, 1) ? BtnTick : BtnNone));
    pushed += 1;
    repeat ($urandom_range(1, run_max)) begin
      r = $urandom_range(0, 99);
      b = ($urandom_range(0, 9) != 0) ? BtnTick : BtnNone;
      if (r < 5) begin
        put(b | BtnStop);
        pushed += 1;
        // ticks and adds are ignored while paused
        repeat ($urandom_range(0, 3)) begin
          put(6'($urandom_range(0, 63)) & ~(BtnStart | BtnStop));
          pushed += 1;
        end
        if ($urandom_range(0, 4) == 0) begin
          put(BtnStop);
          return pushed + 1;
        end
        put(BtnStart | ($urandom_range(0, 1) ? BtnStop : BtnNone));
        pushed += 1;
      end else begin
        if (r < 8) b |= BtnStart;
        else if (r < 11) b |= 6'($urandom_range(0, 63)) & (BtnTenSec | BtnOneMin | BtnTenMin);
        put(b);
        pushed += 1;
      end
    end
    put(BtnStop);
    put(BtnStop);
    return pushed + 2;
  endfunction

  function automatic void log_mismatch(string what, oven_status_t want, oven_status_t got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: %s: want mode=%0d drv=%b%b%b lamps=%b%b mm:ss=%0d:%0d pad=%0d, %s",
               $realtime, what, want.mode, want.motor, want.heater, want.red,
               want.yellow, want.green, want.minutes, want.seconds, want.pad,
               $sformatf("got mode=%0d drv=%b%b%b lamps=%b%b mm:ss=%0d:%0d pad=%0d",
                         got.mode, got.motor, got.heater, got.red, got.yellow,
                         got.green, got.minutes, got.seconds, got.pad));
  endfunction

  // sender: predicts on every accepted item and offers the next after a gap
  btn_t offered = '0;
  int   send_gap = 0;
  int   send_calm = 0;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) status_due.push_back(cook_step(offered));
    if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (button_queue.size() != 0) begin
        offered = button_queue.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {2'b00, offered};
        if (send_calm > 0) begin
          send_calm--;
        end else begin
          send_gap = idle_len();
          if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 80);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  int recv_gap = 0;
  int recv_calm = 0;
  int squeeze_left = 0;
  bit squeeze_done = 1'b0;

  always @(posedge clk_i) begin
    if (squeeze_req && !squeeze_done) begin
      squeeze_left = SqueezeCycles;
      squeeze_done = 1'b1;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      m_axis_tready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (recv_calm > 0) begin
        recv_calm--;
      end else begin
        recv_gap = idle_len();
        if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 80);
      end
    end
  end

  // checker: every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    oven_status_t got;
    oven_status_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      n_results <= n_results + 1;
      if (status_due.size() == 0) begin
        log_mismatch("result with nothing due", '0, got);
      end else begin
        want = status_due.pop_front();
        if (got.mode !== want.mode || got.motor !== want.motor ||
            got.heater !== want.heater || got.red !== want.red ||
            got.yellow !== want.yellow || got.green !== want.green ||
            got.minutes !== want.minutes || got.seconds !== want.seconds ||
            got.pad !== want.pad)
          log_mismatch($sformatf("result %0d differs", n_results), want, got);
      end
    end
  end

  // wait until nothing is in flight, then past the pipeline depth
  task automatic drain();
    do @(negedge clk_i);
    while (button_queue.size() != 0 || s_axis_tvalid_i || status_due.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_cook_limit(logic [19:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_limit = value;
  endtask

  initial begin
    logic [19:0] limits[8];
    int          run_max[8];
    int          add_lo[8];
    int          add_hi[8];
    int          queued;
    limits  = '{LimitMax, 20'd37, 20'd0, 20'd1, 20'd1200, 20'd0, 20'd15, 20'd599900};
    run_max = '{8, 45, 6, 4, 20, 12, 20, 10};
    add_lo  = '{15, 1, 1, 1, 1, 1, 1, 1};
    add_hi  = '{22, 3, 3, 2, 4, 6, 3, 12};
    limits[5] = 20'($urandom_range(1, 1048575));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: priorities in idle, the first heat step, pause and resume
    set_cook_limit(MaxCookReset);
    @(negedge clk_i);
    put(BtnTick);
    put(BtnStart);
    put(BtnStart | BtnTenSec);
    put(BtnTenSec | BtnOneMin | BtnTenMin);
    put(BtnOneMin | BtnTenMin | BtnStop);
    put(BtnTenMin | BtnStop);
    put(BtnStop);
    put(BtnTenSec);
    put(BtnStart | BtnTick | BtnTenMin);
    put(BtnTick);
    put(BtnTick | BtnStart | BtnOneMin);
    put(BtnTick | BtnStop);
    put(BtnTick);
    put(BtnStart | BtnStop);
    put(BtnStop);
    put(BtnStop);
    drain();

    // zero limit: nothing can be added, start stays idle
    set_cook_limit(20'd0);
    @(negedge clk_i);
    put(BtnTenMin);
    put(BtnStart);
    drain();

    // one-tick cook: the last tick ends heat and swallows stop
    set_cook_limit(20'd1);
    @(negedge clk_i);
    put(BtnOneMin);
    put(BtnStart);
    put(BtnTick | BtnStop);
    drain();

    set_cook_limit(LimitMax);
    @(negedge clk_i);
    put(BtnTenMin);
    put(BtnTenMin);
    drain();

    // limit lowered below the current time: the next add pulls it down
    set_cook_limit(20'd5000);
    @(negedge clk_i);
    put(BtnTenSec);
    put(BtnStop);
    drain();

    // random sessions under several limits
    for (int p = 0; p < 8; p++) begin
      set_cook_limit(limits[p]);
      @(negedge clk_i);
      queued = 0;
      while (queued < 40) queued += queue_session(run_max[p], add_lo[p], add_hi[p], p == 0);
      if (p == 1) squeeze_req <= 1'b1;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (bad_results == 0 && status_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// File: files.f
design/octc_pkg.sv
design/octc_ctrl.sv
design/octc_disp.sv
design/oven_cook_timer_controller_unit.sv
tb/sv/testbench.sv
